FILE: src/tlfc_pkg.sv
// Shared types and constants for the three-level FIFO cache model.
package tlfc_pkg;

  localparam int unsigned HitBits = 2;
  localparam int unsigned CountBits = 32;

  localparam logic [1:0] LVL_FIRST = 2'd0;
  localparam logic [1:0] LVL_SECOND = 2'd1;
  localparam logic [1:0] LVL_THIRD = 2'd2;

  typedef enum logic [HitBits-1:0] {
    HIT_L1 = 2'd0,
    HIT_L2 = 2'd1,
    HIT_L3 = 2'd2,
    HIT_RAM = 2'd3
  } hit_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_FIND_START,
    OP_FIND_STEP,
    OP_SHIFT_START,
    OP_SHIFT_STEP,
    OP_APPEND,
    OP_COUNT,
    OP_DROP
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] lvl;
  } tlfc_cmd_t;

  typedef struct packed {
    logic found;
    logic done;
    logic full;
  } tlfc_sts_t;

endpackage

FILE: src/tlfc_datapath.sv
// Tag stores, fill counts, search and compaction datapath.
module tlfc_datapath import tlfc_pkg::*; #(
  parameter int unsigned FIRST_DEPTH = 32,
  parameter int unsigned SECOND_DEPTH = 128,
  parameter int unsigned THIRD_DEPTH = 512,
  parameter int unsigned TAG_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  logic [TAG_BITS-1:0]  tag_i,
  input  tlfc_cmd_t            cmd_i,
  output tlfc_sts_t            sts_o,
  output logic [CountBits-1:0] count_o
);

  localparam int unsigned F1B = $clog2(FIRST_DEPTH + 1);
  localparam int unsigned F2B = $clog2(SECOND_DEPTH + 1);
  localparam int unsigned F3B = $clog2(THIRD_DEPTH + 1);
  localparam int unsigned F12B = (F1B > F2B) ? F1B : F2B;
  localparam int unsigned PB = (F12B > F3B) ? F12B : F3B;
  localparam int unsigned A1B = (FIRST_DEPTH > 1) ? $clog2(FIRST_DEPTH) : 1;
  localparam int unsigned A2B = (SECOND_DEPTH > 1) ? $clog2(SECOND_DEPTH) : 1;
  localparam int unsigned A3B = (THIRD_DEPTH > 1) ? $clog2(THIRD_DEPTH) : 1;

  logic [TAG_BITS-1:0] mem1 [FIRST_DEPTH];
  logic [TAG_BITS-1:0] mem2 [SECOND_DEPTH];
  logic [TAG_BITS-1:0] mem3 [THIRD_DEPTH];

  logic [F1B-1:0] fill1_q;
  logic [F2B-1:0] fill2_q;
  logic [F3B-1:0] fill3_q;
  logic [CountBits-1:0] count_q;
  logic [TAG_BITS-1:0] tag_q;
  logic [TAG_BITS-1:0] ev_q;
  logic [TAG_BITS-1:0] rd_q;
  logic [PB-1:0] pos_q;
  logic rd_ok_q;
  logic found_q;
  logic done_q;

  logic [PB-1:0] fill_sel;
  logic [PB-1:0] depth_sel;
  logic [PB-1:0] pos_n;
  logic [PB-1:0] pos_m;
  logic [PB-1:0] wr_pos;

  always_comb begin
    case (cmd_i.lvl)
      LVL_FIRST: begin
        fill_sel = PB'(fill1_q);
        depth_sel = PB'(FIRST_DEPTH);
      end
      LVL_SECOND: begin
        fill_sel = PB'(fill2_q);
        depth_sel = PB'(SECOND_DEPTH);
      end
      default: begin
        fill_sel = PB'(fill3_q);
        depth_sel = PB'(THIRD_DEPTH);
      end
    endcase
  end

  assign pos_n = pos_q + PB'(1);
  assign pos_m = pos_q - PB'(1);
  assign wr_pos = pos_q - PB'(2);

  // read port, one address per cycle; rd_q holds the entry below pos_q
  always_ff @(posedge clk_i) begin
    case (cmd_i.lvl)
      LVL_FIRST: rd_q <= mem1[pos_q[A1B-1:0]];
      LVL_SECOND: rd_q <= mem2[pos_q[A2B-1:0]];
      default: rd_q <= mem3[pos_q[A3B-1:0]];
    endcase
  end

  // write port
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_SHIFT_STEP && rd_ok_q) begin
      case (cmd_i.lvl)
        LVL_FIRST: mem1[wr_pos[A1B-1:0]] <= rd_q;
        LVL_SECOND: mem2[wr_pos[A2B-1:0]] <= rd_q;
        default: mem3[wr_pos[A3B-1:0]] <= rd_q;
      endcase
    end else if (cmd_i.op == OP_APPEND) begin
      case (cmd_i.lvl)
        LVL_FIRST: mem1[fill_sel[A1B-1:0]] <= tag_q;
        LVL_SECOND: mem2[fill_sel[A2B-1:0]] <= tag_q;
        default: mem3[fill_sel[A3B-1:0]] <= tag_q;
      endcase
    end
  end

  // append the pending tag, then carry the evicted one down a level
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      tag_q <= tag_i;
    end else if (cmd_i.op == OP_APPEND) begin
      tag_q <= ev_q;
    end
  end

  // capture the oldest entry before compaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_SHIFT_START) begin
      ev_q <= rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill1_q <= '0;
      fill2_q <= '0;
      fill3_q <= '0;
      count_q <= '0;
      pos_q <= '0;
      rd_ok_q <= 1'b0;
      found_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        OP_FIND_START: begin
          pos_q <= '0;
          rd_ok_q <= 1'b0;
          found_q <= 1'b0;
          done_q <= (fill_sel == '0);
        end
        OP_FIND_STEP: begin
          if (rd_ok_q && rd_q == tag_q) begin
            found_q <= 1'b1;
            done_q <= 1'b1;
            pos_q <= pos_m;
          end else if (pos_q >= fill_sel) begin
            done_q <= 1'b1;
          end else begin
            pos_q <= pos_n;
            rd_ok_q <= 1'b1;
          end
        end
        OP_SHIFT_START: begin
          pos_q <= pos_n;
          rd_ok_q <= 1'b0;
          done_q <= 1'b0;
        end
        OP_SHIFT_STEP: begin
          if (pos_q >= fill_sel) begin
            done_q <= 1'b1;
            rd_ok_q <= 1'b0;
            case (cmd_i.lvl)
              LVL_FIRST: fill1_q <= fill1_q - F1B'(1);
              LVL_SECOND: fill2_q <= fill2_q - F2B'(1);
              default: fill3_q <= fill3_q - F3B'(1);
            endcase
          end else begin
            rd_ok_q <= 1'b1;
            pos_q <= pos_n;
          end
        end
        OP_APPEND: begin
          case (cmd_i.lvl)
            LVL_FIRST: fill1_q <= fill1_q + F1B'(1);
            LVL_SECOND: fill2_q <= fill2_q + F2B'(1);
            default: fill3_q <= fill3_q + F3B'(1);
          endcase
        end
        OP_COUNT: count_q <= count_q + CountBits'(1);
        OP_DROP: begin
          pos_q <= '0;
        end
        default: begin
          pos_q <= pos_q;
        end
      endcase
    end
  end

  assign sts_o.found = found_q;
  assign sts_o.done = done_q;
  assign sts_o.full = (fill_sel >= depth_sel);
  assign count_o = count_q;

endmodule

FILE: src/tlfc_ctrl.sv
// Access sequencer for the three-level FIFO cache model.
module tlfc_ctrl import tlfc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  output logic        load_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  hit_o,
  output tlfc_cmd_t   cmd_o,
  input  tlfc_sts_t   sts_i
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_FINDS  = 4'd1;
  localparam logic [3:0] S_FIND   = 4'd2;
  localparam logic [3:0] S_REMS   = 4'd3;
  localparam logic [3:0] S_REM    = 4'd4;
  localparam logic [3:0] S_INS    = 4'd5;
  localparam logic [3:0] S_EVRD   = 4'd6;
  localparam logic [3:0] S_EVRD2  = 4'd7;
  localparam logic [3:0] S_EVCAP  = 4'd8;
  localparam logic [3:0] S_APP    = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;
  localparam logic [3:0] S_PEND   = 4'd11;

  logic [3:0] state_q, state_d;
  logic [1:0] lvl_q, lvl_d;
  logic [1:0] hit_q, hit_d;
  logic       evict_q, evict_d;

  always_comb begin
    state_d = state_q;
    lvl_d = lvl_q;
    hit_d = hit_q;
    evict_d = evict_q;
    cmd_o.op = OP_NONE;
    cmd_o.lvl = lvl_q;
    load_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          load_o = 1'b1;
          lvl_d = LVL_FIRST;
          state_d = S_FINDS;
        end
      end
      S_FINDS: begin
        cmd_o.op = OP_FIND_START;
        state_d = S_FIND;
      end
      S_FIND: begin
        if (sts_i.done) begin
          if (sts_i.found) begin
            hit_d = lvl_q;
            if (lvl_q == LVL_FIRST) begin
              state_d = S_OUT;
            end else begin
              state_d = S_REMS;
            end
          end else if (lvl_q == LVL_THIRD) begin
            hit_d = HIT_RAM;
            cmd_o.op = OP_COUNT;
            lvl_d = LVL_FIRST;
            evict_d = 1'b0;
            state_d = S_INS;
          end else begin
            lvl_d = lvl_q + 2'd1;
            state_d = S_FINDS;
          end
        end else begin
          cmd_o.op = OP_FIND_STEP;
        end
      end
      S_REMS: begin
        cmd_o.op = OP_SHIFT_START;
        state_d = S_REM;
      end
      S_REM: begin
        cmd_o.op = OP_SHIFT_STEP;
        if (sts_i.done) begin
          cmd_o.op = OP_NONE;
          if (evict_q) begin
            state_d = S_APP;
          end else begin
            lvl_d = LVL_FIRST;
            state_d = S_INS;
          end
        end
      end
      S_INS: begin
        if (sts_i.full) begin
          evict_d = 1'b1;
          state_d = S_EVRD;
        end else begin
          evict_d = 1'b0;
          state_d = S_APP;
        end
      end
      S_EVRD: begin
        cmd_o.op = OP_DROP;
        state_d = S_EVRD2;
      end
      S_EVRD2: begin
        state_d = S_EVCAP;
      end
      S_EVCAP: begin
        cmd_o.op = OP_SHIFT_START;
        state_d = S_PEND;
      end
      S_PEND: begin
        state_d = S_REM;
      end
      S_APP: begin
        cmd_o.op = OP_APPEND;
        evict_d = 1'b0;
        if (evict_q && lvl_q != LVL_THIRD) begin
          lvl_d = lvl_q + 2'd1;
          state_d = S_INS;
        end else begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      lvl_q <= LVL_FIRST;
      hit_q <= HIT_L1;
      evict_q <= 1'b0;
    end else begin
      state_q <= state_d;
      lvl_q <= lvl_d;
      hit_q <= hit_d;
      evict_q <= evict_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign hit_o = hit_q;

endmodule

FILE: src/three_level_fifo_cache_model.sv
// Top level of the three-level exclusive FIFO cache model.
//  channel | signals                                    | direction
//  in      | in_valid_i, in_stall_o, block_tag_i        | into block
//  out     | out_valid_o, out_stall_i, hit_level_o,      | out of block
//          | ram_access_count_o                          |
// One item at a time; the single tag-store port is walked one entry per cycle
// in the search of each level, the removal of a hit entry from its level, the
// insert, and the eviction from each full level, before the result is shown.
// Reset empties all levels and clears the RAM fetch count; no clearing pass.
// A stalled result holds; no new item is taken until it leaves.
module three_level_fifo_cache_model import tlfc_pkg::*; #(
  parameter int unsigned FIRST_DEPTH = 32,
  parameter int unsigned SECOND_DEPTH = 128,
  parameter int unsigned THIRD_DEPTH = 512,
  parameter int unsigned TAG_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] block_tag_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  hit_level_o,
  output logic [31:0] ram_access_count_o
);

  tlfc_cmd_t cmd;
  tlfc_sts_t sts;
  logic load;

  tlfc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .load_o      (load),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .hit_o       (hit_level_o),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  tlfc_datapath #(
    .FIRST_DEPTH  (FIRST_DEPTH),
    .SECOND_DEPTH (SECOND_DEPTH),
    .THIRD_DEPTH  (THIRD_DEPTH),
    .TAG_BITS     (TAG_BITS)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .tag_i   (TAG_BITS'(block_tag_i)),
    .cmd_i   (cmd),
    .sts_o   (sts),
    .count_o (ram_access_count_o)
  );

endmodule

FILE: src/tlfc_checker.sv
// Port-level checks for the three-level FIFO cache model.
module tlfc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  hit_level_o,
  input logic [31:0] ram_access_count_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(hit_level_o))
    else $error("result changed under stall");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while result pending");

  a_count_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_level_o != 2'd3 && $past(!out_valid_o) |->
    $stable(ram_access_count_o))
    else $error("count moved on a hit");

endmodule

bind three_level_fifo_cache_model tlfc_checker u_tlfc_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_stall_o         (in_stall_o),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .hit_level_o        (hit_level_o),
  .ram_access_count_o (ram_access_count_o)
);

FILE: sim/three_level_fifo_cache_model_tb.sv
// Self-checking testbench for the three-level exclusive FIFO cache model.
`timescale 1ns / 1ps

module three_level_fifo_cache_model_tb;
  import tlfc_pkg::*;

  localparam int unsigned L1Depth = 32;
  localparam int unsigned L2Depth = 128;
  localparam int unsigned L3Depth = 512;
  localparam int unsigned NumRandom = 520;
  localparam int unsigned Watchdog = 40000;
  localparam int unsigned HoldCycles = 400;

  typedef struct packed {
    logic [15:0] tag;
    logic        typed;
    hit_e        level;
    logic [31:0] count;
  } access_row_t;

  typedef struct packed {
    hit_e        level;
    logic [31:0] count;
  } lookup_t;

  localparam int unsigned NumDirected = 12;
  localparam access_row_t AccessTable [NumDirected] = '{
    '{16'h0000, 1'b1, HIT_RAM, 32'd1},
    '{16'hffff, 1'b1, HIT_RAM, 32'd2},
    '{16'h0000, 1'b1, HIT_L1, 32'd2},
    '{16'hffff, 1'b1, HIT_L1, 32'd2},
    '{16'h5555, 1'b1, HIT_RAM, 32'd3},
    '{16'haaaa, 1'b1, HIT_RAM, 32'd4},
    '{16'h0001, 1'b1, HIT_RAM, 32'd5},
    '{16'h8000, 1'b1, HIT_RAM, 32'd6},
    '{16'h5555, 1'b1, HIT_L1, 32'd6},
    '{16'h7fff, 1'b0, HIT_L1, 32'd0},
    '{16'hfffe, 1'b0, HIT_L1, 32'd0},
    '{16'h0000, 1'b0, HIT_L1, 32'd0}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [15:0] block_tag_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  hit_level_o;
  logic [31:0] ram_access_count_o;

  logic [15:0] l1_tags [$];
  logic [15:0] l2_tags [$];
  logic [15:0] l3_tags [$];
  logic [15:0] recent_tags [$];
  logic [31:0] ram_fetches;
  lookup_t     pending_lookups [$];

  int unsigned items_sent;
  int unsigned idle_cycles;
  int unsigned hold_left;
  int unsigned mode;
  logic        hold_done;
  logic        failed;

  three_level_fifo_cache_model dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .block_tag_i,
    .out_valid_o,
    .out_stall_i,
    .hit_level_o,
    .ram_access_count_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic int find_tag(ref logic [15:0] store [$], input logic [15:0] tag);
    for (int i = 0; i < store.size(); i++) begin
      if (store[i] == tag) return i;
    end
    return -1;
  endfunction

  task automatic push_third(input logic [15:0] tag);
    if (find_tag(l3_tags, tag) >= 0) return;
    if (l3_tags.size() >= int'(L3Depth)) l3_tags.delete(0);
    l3_tags.insert(l3_tags.size(), tag);
  endtask

  task automatic push_second(input logic [15:0] tag);
    logic [15:0] oldest;
    if (find_tag(l2_tags, tag) >= 0) return;
    if (l2_tags.size() >= int'(L2Depth)) begin
      oldest = l2_tags[0];
      l2_tags.delete(0);
      push_third(oldest);
    end
    l2_tags.insert(l2_tags.size(), tag);
  endtask

  task automatic push_first(input logic [15:0] tag);
    logic [15:0] oldest;
    if (find_tag(l1_tags, tag) >= 0) return;
    if (l1_tags.size() >= int'(L1Depth)) begin
      oldest = l1_tags[0];
      l1_tags.delete(0);
      push_second(oldest);
    end
    l1_tags.insert(l1_tags.size(), tag);
  endtask

  task automatic lookup_tag(input logic [15:0] tag, output lookup_t res);
    int pos1;
    int pos2;
    int pos3;
    pos1 = find_tag(l1_tags, tag);
    pos2 = find_tag(l2_tags, tag);
    pos3 = find_tag(l3_tags, tag);
    if (pos1 >= 0) begin
      res.level = HIT_L1;
    end else if (pos2 >= 0) begin
      res.level = HIT_L2;
      l2_tags.delete(pos2);
      push_first(tag);
    end else if (pos3 >= 0) begin
      res.level = HIT_L3;
      l3_tags.delete(pos3);
      push_first(tag);
    end else begin
      res.level = HIT_RAM;
      ram_fetches = ram_fetches + 32'd1;
      push_first(tag);
    end
    res.count = ram_fetches;
  endtask

  function automatic logic [15:0] pick_tag(input int unsigned idx);
    if (idx < NumDirected) return AccessTable[idx].tag;
    if (recent_tags.size() > 0 && $urandom_range(0, 99) < 65) begin
      return recent_tags[$urandom_range(0, recent_tags.size() - 1)];
    end
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic sender_idles(input int unsigned m);
    case (m)
      1: return $urandom_range(0, 99) < 52;
      3: return $urandom_range(0, 99) < 11;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic receiver_stalls(input int unsigned m);
    case (m)
      2: return $urandom_range(0, 99) < 52;
      3: return $urandom_range(0, 99) < 11;
      default: return 1'b0;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_t res;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      block_tag_i <= '0;
      items_sent = 0;
      mode = 0;
      ram_fetches = '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        lookup_tag(block_tag_i, res);
        if (items_sent < NumDirected && AccessTable[items_sent].typed) begin
          res.level = AccessTable[items_sent].level;
          res.count = AccessTable[items_sent].count;
        end
        pending_lookups.insert(pending_lookups.size(), res);
        recent_tags.insert(recent_tags.size(), block_tag_i);
        if (recent_tags.size() > 180) recent_tags.delete(0);
        items_sent++;
        mode = (items_sent < NumDirected) ? 0 : ((items_sent - NumDirected) / 130) % 4;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (items_sent >= NumDirected + NumRandom || sender_idles(mode)) begin
          in_valid_i <= 1'b0;
        end else begin
          in_valid_i <= 1'b1;
          block_tag_i <= pick_tag(items_sent);
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_t exp_res;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
      failed = 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_lookups.size() == 0) begin
          $error("unexpected item: hit_level %0d ram_access_count %0d",
                 hit_level_o, ram_access_count_o);
          failed = 1'b1;
        end else begin
          exp_res = pending_lookups[0];
          pending_lookups.delete(0);
          if (hit_level_o !== exp_res.level) begin
            $error("hit_level: expected %0d, actual %0d", exp_res.level, hit_level_o);
            failed = 1'b1;
          end
          if (ram_access_count_o !== exp_res.count) begin
            $error("ram_access_count: expected %0d, actual %0d",
                   exp_res.count, ram_access_count_o);
            failed = 1'b1;
          end
        end
      end
      if (!hold_done && items_sent >= NumDirected + 5) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= receiver_stalls(mode);
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= Watchdog) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (rst_ni === 1'b1);
    while (items_sent < NumDirected + NumRandom || pending_lookups.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (100) @(posedge clk_i);
    if (!failed && pending_lookups.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
